>>> src/pfa_pkg.sv
package pfa_pkg;

    // Field widths fixed by the item formats.
    localparam int FUNC_W   = 2;
    localparam int PAGE_W   = 15;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int FLAG_W   = 2;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'd1;

    localparam logic [PAGE_W-1:0] LOW_LIMIT_RESET  = 15'd256;
    localparam logic [PAGE_W-1:0] KERNEL_END_RESET = 15'd0;

    localparam int POOL_FRAMES_DEFAULT = 32768;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOGRP = 2'd2;

    // Per-frame flags: bit 0 available, bit 1 used.
    localparam int AVAIL_BIT = 0;
    localparam int USED_BIT  = 1;
    localparam logic [FLAG_W-1:0] FLAGS_CLEAR = 2'b00;
    localparam logic [FLAG_W-1:0] FLAGS_AVAIL = 2'b01;
    localparam logic [FLAG_W-1:0] FLAGS_TAKEN = 2'b11;

    typedef struct packed {
        logic [PAGE_W-1:0] low_limit_page;
        logic [PAGE_W-1:0] kernel_end_page;
    } pfa_cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PAGE_W-1:0]  page_number;
        logic [COUNT_W-1:0] page_count;
    } pfa_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   block_page;
        logic [COUNT_W-1:0]  used_frames;
        logic [COUNT_W-1:0]  total_frames;
    } pfa_result_t;

endpackage

>>> src/pfa_if.sv
interface pfa_req_if;
    import pfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [PAGE_W-1:0]  page_number;
    logic [COUNT_W-1:0] page_count;

    modport source (output valid, func, page_number, page_count, input ready);
    modport sink   (input valid, func, page_number, page_count, output ready);
endinterface

interface pfa_rsp_if;
    import pfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   block_page;
    logic [COUNT_W-1:0]  used_frames;
    logic [COUNT_W-1:0]  total_frames;

    modport source (output valid, status, block_page, used_frames, total_frames,
                    input ready);
    modport sink   (input valid, status, block_page, used_frames, total_frames,
                    output ready);
endinterface

>>> src/pfa_frame_mem.sv
module pfa_frame_mem #(
    parameter int POOL_FRAMES = pfa_pkg::POOL_FRAMES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rd_en,
    input  logic [$clog2(POOL_FRAMES)-1:0]        rd_addr,
    input  logic                                  wr_en,
    input  logic [$clog2(POOL_FRAMES)-1:0]        wr_addr,
    input  logic [pfa_pkg::FLAG_W-1:0]            wr_data,
    output logic [pfa_pkg::FLAG_W-1:0]            rd_data
);
    import pfa_pkg::*;

    // One flag pair per page frame; simple dual port, registered read.
    logic [FLAG_W-1:0] flags_mem [0:POOL_FRAMES-1];
    logic [FLAG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flags_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= flags_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pfa_ctrl.sv
module pfa_ctrl #(
    parameter int POOL_FRAMES = pfa_pkg::POOL_FRAMES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfa_pkg::pfa_cfg_t    cfg,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  pfa_pkg::pfa_req_t    req,
    output logic                 res_valid,
    input  logic                 res_taken,
    output pfa_pkg::pfa_result_t res
);
    import pfa_pkg::*;

    localparam int IDX_W  = $clog2(POOL_FRAMES);
    localparam int SCAN_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 2;
    localparam logic [SCAN_W-1:0] POOL_S = SCAN_W'(POOL_FRAMES);
    localparam logic [SCAN_W-1:0] LAST_S = SCAN_W'(POOL_FRAMES - 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADD_RD   = 4'd2;
    localparam logic [3:0] S_ADD_WB   = 4'd3;
    localparam logic [3:0] S_ALC_RD   = 4'd4;
    localparam logic [3:0] S_ALC_CHK  = 4'd5;
    localparam logic [3:0] S_ALC_MARK = 4'd6;
    localparam logic [3:0] S_FREE_RD  = 4'd7;
    localparam logic [3:0] S_FREE_WB  = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [SCAN_W-1:0]   ptr_reg, ptr_next;
    logic [SCAN_W-1:0]   lim_reg, lim_next;
    logic [SCAN_W-1:0]   base_reg, base_next;
    logic [SCAN_W-1:0]   grp_end_reg, grp_end_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [COUNT_W-1:0]  used_reg, used_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PAGE_W-1:0]   block_reg, block_next;

    logic                mem_rd_en;
    logic                mem_wr_en;
    logic [FLAG_W-1:0]   mem_wr_data;
    logic [FLAG_W-1:0]   mem_rd_data;

    logic [SCAN_W-1:0]   ptr_inc;
    logic [SCAN_W-1:0]   sum_end;
    logic [SCAN_W-1:0]   clip_end;
    logic [PAGE_W-1:0]   start_a;
    logic [PAGE_W-1:0]   start_b;
    logic [PAGE_W-1:0]   add_start;
    logic                add_drop;
    logic                no_memory;
    logic [SCAN_W-1:0]   next_grp_end;

    pfa_frame_mem #(
        .POOL_FRAMES (POOL_FRAMES)
    ) u_frame_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .wr_en   (mem_wr_en),
        .wr_addr (ptr_reg[IDX_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    // Item decode, evaluated against the word offered on the input.
    always_comb
    begin
        ptr_inc  = ptr_reg + SCAN_W'(1);
        sum_end  = SCAN_W'(req.page_number) + SCAN_W'(req.page_count);
        clip_end = (sum_end > POOL_S) ? POOL_S : sum_end;

        start_a   = (req.page_number < cfg.low_limit_page) ? cfg.low_limit_page
                                                           : req.page_number;
        start_b   = (start_a < cfg.kernel_end_page) ? cfg.kernel_end_page : start_a;
        add_start = (start_b == '0) ? PAGE_W'(1) : start_b;
        add_drop  = (req.page_number < cfg.low_limit_page) &&
                    (req.page_count < COUNT_W'(cfg.low_limit_page));

        no_memory = (({1'b0, used_reg} + {1'b0, req.page_count}) >= {1'b0, total_reg});

        next_grp_end = grp_end_reg + SCAN_W'(n_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        lim_next    = lim_reg;
        base_next   = base_reg;
        grp_end_next = grp_end_reg;
        n_next      = n_reg;
        used_next   = used_reg;
        total_next  = total_reg;
        status_next = status_reg;
        block_next  = block_reg;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_data = FLAGS_CLEAR;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en = 1'b1;
                if (ptr_reg == LAST_S)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = STATUS_OK;
                    block_next  = '0;
                    state_next  = S_DONE;
                    unique case (req.func)
                        FUNC_ADD:
                        begin
                            if (!add_drop && (SCAN_W'(add_start) < clip_end))
                            begin
                                ptr_next   = SCAN_W'(add_start);
                                lim_next   = clip_end;
                                state_next = S_ADD_RD;
                            end
                        end
                        FUNC_ALLOC:
                        begin
                            n_next = req.page_count;
                            if (no_memory)
                            begin
                                status_next = STATUS_NOMEM;
                            end
                            else if ((req.page_count == '0) ||
                                     (SCAN_W'(req.page_count) > POOL_S))
                            begin
                                status_next = STATUS_NOGRP;
                            end
                            else
                            begin
                                ptr_next     = '0;
                                base_next    = '0;
                                grp_end_next = SCAN_W'(req.page_count);
                                state_next   = S_ALC_RD;
                            end
                        end
                        FUNC_FREE:
                        begin
                            if (SCAN_W'(req.page_number) < clip_end)
                            begin
                                ptr_next   = SCAN_W'(req.page_number);
                                lim_next   = clip_end;
                                state_next = S_FREE_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_ADD_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_ADD_WB;
            end

            S_ADD_WB:
            begin
                if (!mem_rd_data[AVAIL_BIT])
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = mem_rd_data | FLAGS_AVAIL;
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + COUNT_W'(1);
                    end
                end
                if (ptr_inc >= lim_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_ADD_RD;
                end
            end

            S_ALC_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_ALC_CHK;
            end

            S_ALC_CHK:
            begin
                if (mem_rd_data == FLAGS_AVAIL)
                begin
                    if (ptr_inc == grp_end_reg)
                    begin
                        ptr_next   = base_reg;
                        state_next = S_ALC_MARK;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_ALC_RD;
                    end
                end
                else if (next_grp_end > POOL_S)
                begin
                    status_next = STATUS_NOGRP;
                    state_next  = S_DONE;
                end
                else
                begin
                    base_next    = grp_end_reg;
                    ptr_next     = grp_end_reg;
                    grp_end_next = next_grp_end;
                    state_next   = S_ALC_RD;
                end
            end

            S_ALC_MARK:
            begin
                // Every frame of the group was seen available and unused.
                mem_wr_en   = 1'b1;
                mem_wr_data = FLAGS_TAKEN;
                if (ptr_inc == grp_end_reg)
                begin
                    used_next   = used_reg + n_reg;
                    block_next  = base_reg[PAGE_W-1:0];
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end

            S_FREE_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_FREE_WB;
            end

            S_FREE_WB:
            begin
                if (mem_rd_data[USED_BIT])
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = mem_rd_data & FLAGS_AVAIL;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - COUNT_W'(1);
                    end
                end
                if (ptr_inc >= lim_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_FREE_RD;
                end
            end

            S_DONE:
            begin
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            used_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            used_reg  <= used_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg     <= lim_next;
        base_reg    <= base_next;
        grp_end_reg <= grp_end_next;
        n_reg       <= n_next;
        status_reg  <= status_next;
        block_reg   <= block_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status       = status_reg;
    assign res.block_page   = block_reg;
    assign res.used_frames  = used_reg;
    assign res.total_frames = total_reg;

endmodule

>>> src/page_frame_allocator.sv
// Page frame allocator: an item is decoded when idle and finished in the done state.
// Add region and free read each page and write it back where needed; allocate reads and
// checks frames in turn, then marks each frame of the found group in the flag memory.
// One item is in work at a time; a finished result waits in the output register.
// After reset the flag memory is swept clear before an item is taken.
// Reset is asynchronous and active low; configuration returns to its default values.
module page_frame_allocator #(
    parameter int POOL_FRAMES = pfa_pkg::POOL_FRAMES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::PAGE_W-1:0]      cfg_wdata,
    pfa_req_if.sink                         req,
    pfa_rsp_if.source                       rsp
);
    import pfa_pkg::*;

    // Configuration registers. They are only to be written while the block is idle;
    // that is left to the user, so the controller may read them directly during an operation.
    pfa_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_limit_page  <= LOW_LIMIT_RESET;
            cfg_reg.kernel_end_page <= KERNEL_END_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LOW_LIMIT)
            begin
                cfg_reg.low_limit_page <= cfg_wdata;
            end
            if (cfg_index == CFG_KERNEL_END)
            begin
                cfg_reg.kernel_end_page <= cfg_wdata;
            end
        end
    end

    // The input word is handed to the controller as one record.
    pfa_req_t    req_word;
    pfa_result_t ctrl_res;
    logic        ctrl_res_valid;
    logic        ctrl_res_taken;

    assign req_word.func        = req.func;
    assign req_word.page_number = req.page_number;
    assign req_word.page_count  = req.page_count;

    pfa_ctrl #(
        .POOL_FRAMES (POOL_FRAMES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_word),
        .res_valid (ctrl_res_valid),
        .res_taken (ctrl_res_taken),
        .res       (ctrl_res)
    );

    // Output register. The controller hands over its result when the register
    // is empty or its word is being taken in the same cycle, and then returns
    // to idle so the next word can be accepted while this one waits.
    logic        rsp_valid_reg, rsp_valid_next;
    pfa_result_t rsp_data_reg;

    assign ctrl_res_taken = ctrl_res_valid && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl_res_taken)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_res_taken)
        begin
            rsp_data_reg <= ctrl_res;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_data_reg.status;
    assign rsp.block_page   = rsp_data_reg.block_page;
    assign rsp.used_frames  = rsp_data_reg.used_frames;
    assign rsp.total_frames = rsp_data_reg.total_frames;

endmodule

>>> bench/tb_page_frame_allocator.sv
`timescale 1ns / 100ps

import pfa_pkg::*;

// One block that the allocator handed out and that may later be freed again.
typedef struct {
    int unsigned page;
    int unsigned count;
} block_t;

// Tracks the frame pool the way the allocator should, one request word at a time,
// and holds the result words that are still owed by the block.
class frame_book;
    localparam int POOL = POOL_FRAMES_DEFAULT;

    bit [FLAG_W-1:0] flags [POOL];
    int unsigned     used_count;
    int unsigned     total_count;
    int unsigned     low_limit;
    int unsigned     kern_floor;
    pfa_result_t     pending_results[$];
    block_t          live_blocks[$];
    int              errors;
    int              shown;

    function new();
        foreach (flags[i])
            flags[i] = FLAGS_CLEAR;
        used_count  = 0;
        total_count = 0;
        low_limit   = 32'(LOW_LIMIT_RESET);
        kern_floor  = 32'(KERNEL_END_RESET);
        errors      = 0;
        shown       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] value);
        if (idx == CFG_LOW_LIMIT)
            low_limit = 32'(value);
        else if (idx == CFG_KERNEL_END)
            kern_floor = 32'(value);
    endfunction

    function void mark_region(int unsigned first, int unsigned count);
        int unsigned stop;
        int unsigned start;
        stop  = first + count;
        start = first;
        if (first < low_limit && count < low_limit)
            return;
        if (start < low_limit)
            start = low_limit;
        if (start < kern_floor)
            start = kern_floor;
        if (start == 0)
            start = 1;
        if (stop > POOL)
            stop = POOL;
        for (int unsigned p = start; p < stop; p++)
        begin
            if (!flags[p][AVAIL_BIT])
            begin
                flags[p][AVAIL_BIT] = 1'b1;
                if (total_count < 16'hFFFF)
                    total_count++;
            end
        end
    endfunction

    function logic [STATUS_W-1:0] grab_frames(int unsigned n, output int unsigned block);
        bit fits;
        block = 0;
        if (used_count + n >= total_count)
            return STATUS_NOMEM;
        if (n == 0)
            return STATUS_NOGRP;
        for (int unsigned i = 0; i + n <= POOL; i += n)
        begin
            fits = 1'b1;
            for (int unsigned j = 0; j < n; j++)
            begin
                if (flags[i + j][USED_BIT] || !flags[i + j][AVAIL_BIT])
                begin
                    fits = 1'b0;
                    break;
                end
            end
            if (fits)
            begin
                for (int unsigned j = 0; j < n; j++)
                    flags[i + j][USED_BIT] = 1'b1;
                used_count += n;
                block = i;
                return STATUS_OK;
            end
        end
        return STATUS_NOGRP;
    endfunction

    function void release_frames(int unsigned first, int unsigned count);
        int unsigned p;
        for (int unsigned i = 0; i < count; i++)
        begin
            p = first + i;
            if (p >= POOL)
                break;
            if (flags[p][USED_BIT])
            begin
                flags[p][USED_BIT] = 1'b0;
                if (used_count > 0)
                    used_count--;
            end
        end
    endfunction

    function void note_request(pfa_req_t w);
        pfa_result_t r;
        int unsigned block;
        block_t      b;
        r.status = STATUS_OK;
        block    = 0;
        case (w.func)
            FUNC_ADD:
                mark_region(32'(w.page_number), 32'(w.page_count));
            FUNC_ALLOC:
            begin
                r.status = grab_frames(32'(w.page_count), block);
                if (r.status == STATUS_OK)
                begin
                    b.page  = block;
                    b.count = 32'(w.page_count);
                    live_blocks.push_back(b);
                end
            end
            FUNC_FREE:
                release_frames(32'(w.page_number), 32'(w.page_count));
            default:
                ;
        endcase
        r.block_page   = block[PAGE_W-1:0];
        r.used_frames  = used_count[COUNT_W-1:0];
        r.total_frames = total_count[COUNT_W-1:0];
        pending_results.push_back(r);
    endfunction

    function void check_result(pfa_result_t got);
        pfa_result_t want;
        if (pending_results.size() == 0)
        begin
            errors++;
            if (shown < 10)
            begin
                $display("%0t: result word with nothing owed:", $time);
                $display("    status %0d block %0d used %0d total %0d",
                         got.status, got.block_page, got.used_frames, got.total_frames);
            end
            shown++;
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status || got.block_page !== want.block_page ||
            got.used_frames !== want.used_frames || got.total_frames !== want.total_frames)
        begin
            errors++;
            if (shown < 10)
            begin
                $display("%0t: mismatch: expected status %0d block %0d used %0d total %0d,",
                         $time, want.status, want.block_page, want.used_frames,
                         want.total_frames);
                $display("    got status %0d block %0d used %0d total %0d",
                         got.status, got.block_page, got.used_frames, got.total_frames);
            end
            shown++;
        end
    endfunction
endclass

module tb_page_frame_allocator;

    // The request field allows a fourth code that the block must treat as a no-op.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Every request word yields exactly one result word, so once nothing is owed the
    // block is idle; this short pause only covers the output register settling.
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 100;
    localparam int HOLD_CYCLES   = 3000;
    localparam int WORDS_PER_PHASE = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PAGE_W-1:0]    cfg_wdata;

    pfa_req_if req_bus ();
    pfa_rsp_if rsp_bus ();

    // Percent chance per cycle that the sender or the receiver sits out.
    int req_idle_pct;
    int rsp_idle_pct;
    // Cycles left in a forced receiver stall; counted down by the receiver process.
    int hold_left;

    frame_book   book = new();
    pfa_result_t got_word;

    page_frame_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. The slowest item the stimulus can build is a failed scan of the whole
    // pool or a walk over most of it; even if every one of the about 140 words took that
    // long, the run would stay well below this bound.
    initial
    begin
        #2_000_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Build a request word from plain numbers, truncated to the port widths.
    function automatic pfa_req_t make_word(logic [FUNC_W-1:0] f, int unsigned page,
                                           int unsigned count);
        pfa_req_t w;
        w.func        = f;
        w.page_number = page[PAGE_W-1:0];
        w.page_count  = count[COUNT_W-1:0];
        return w;
    endfunction

    // Random traffic. Most frees return a block that the allocator really handed out,
    // so the pool keeps cycling between used and free; the rest are stray frees,
    // oversized or zero requests and unused codes.
    function automatic pfa_req_t pick_word();
        int unsigned roll;
        int unsigned idx;
        block_t      b;
        roll = $urandom_range(99);
        if (roll < 28)
        begin
            if ($urandom_range(9) < 9)
                return make_word(FUNC_ADD, $urandom_range(4095), $urandom_range(400));
            return make_word(FUNC_ADD, $urandom_range(32767), $urandom_range(1500));
        end
        if (roll < 68)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
                return make_word(FUNC_ALLOC, 0, $urandom_range(16, 1));
            if (roll < 88)
                return make_word(FUNC_ALLOC, $urandom_range(32767), 0);
            if (roll < 95)
                return make_word(FUNC_ALLOC, 0, $urandom_range(64, 17));
            // Never fewer frames than the pool holds, so it is refused at once.
            return make_word(FUNC_ALLOC, $urandom_range(32767), $urandom_range(65535, 32768));
        end
        if (roll < 93)
        begin
            if (book.live_blocks.size() != 0 && $urandom_range(3) != 0)
            begin
                idx = $urandom_range(book.live_blocks.size() - 1);
                b   = book.live_blocks[idx];
                book.live_blocks.delete(idx);
                return make_word(FUNC_FREE, b.page, b.count);
            end
            return make_word(FUNC_FREE, $urandom_range(32767), $urandom_range(40));
        end
        return make_word(FUNC_UNUSED, $urandom_range(32767), $urandom_range(65535));
    endfunction

    // Offer one request word, idling first at random, and book it once the block
    // takes it. Called and left just after a falling edge.
    task automatic send_word(input pfa_req_t w);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.func        <= w.func;
        req_bus.page_number <= w.page_number;
        req_bus.page_count  <= w.page_count;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        book.note_request(w);
        @(negedge clk);
    endtask

    // Stop offering, wait until every owed result word has come back, then let the
    // block settle.
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (book.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers one after the other; the enable stays high between them.
    task automatic set_config(input logic [PAGE_W-1:0] low, input logic [PAGE_W-1:0] kern);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_LIMIT;
        cfg_wdata <= low;
        book.set_reg(CFG_LOW_LIMIT, low);
        @(negedge clk);
        cfg_index <= CFG_KERNEL_END;
        cfg_wdata <= kern;
        book.set_reg(CFG_KERNEL_END, kern);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: decides ready at each falling edge, either by the idle chance of the
    // current phase or, during a forced stall, held low for a counted stretch.
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // Result words are taken at the rising edge where valid and ready meet.
    always @(posedge clk)
    begin
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            got_word.status       = rsp_bus.status;
            got_word.block_page   = rsp_bus.block_page;
            got_word.used_frames  = rsp_bus.used_frames;
            got_word.total_frames = rsp_bus.total_frames;
            book.check_result(got_word);
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_LOW_LIMIT;
        cfg_wdata           = '0;
        req_bus.valid       = 1'b0;
        req_bus.func        = FUNC_ADD;
        req_bus.page_number = '0;
        req_bus.page_count  = '0;
        req_idle_pct        = 38;
        rsp_idle_pct        = 75;
        hold_left           = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, registers at their reset values (low limit 256, no kernel).
        // An empty pool refuses even a zero-sized request as out of memory.
        send_word(make_word(FUNC_ALLOC, 0, 0));
        send_word(make_word(FUNC_UNUSED, 32767, 65535));
        // Below the low limit and shorter than it: the region is dropped.
        send_word(make_word(FUNC_ADD, 100, 50));
        // Below the limit but long enough: the start is raised to 256, end kept at 400.
        send_word(make_word(FUNC_ADD, 100, 300));
        // Overlaps pages that are already available; only the new ones count.
        send_word(make_word(FUNC_ADD, 300, 200));
        // With frames to spare, a zero count is a failed search.
        send_word(make_word(FUNC_ALLOC, 0, 0));
        send_word(make_word(FUNC_ALLOC, 0, 1));
        send_word(make_word(FUNC_ALLOC, 0, 4));
        send_word(make_word(FUNC_ALLOC, 0, 32768));
        send_word(make_word(FUNC_ALLOC, 0, 65535));
        // A second free of the same frame must not lower the count again.
        send_word(make_word(FUNC_FREE, 256, 1));
        send_word(make_word(FUNC_FREE, 256, 1));
        // Runs past the pool end, where it must stop.
        send_word(make_word(FUNC_FREE, 32767, 65535));
        drain();

        // Both registers at zero: page zero must still never become available.
        set_config(15'd0, 15'd0);
        send_word(make_word(FUNC_ADD, 0, 10));
        send_word(make_word(FUNC_ADD, 32760, 32768));
        send_word(make_word(FUNC_ALLOC, 0, 1));
        drain();

        // Both registers at their top value.
        set_config(15'd32767, 15'd32767);
        send_word(make_word(FUNC_ADD, 5, 32766));
        // Start raised to the limit, but the end stays where it was: nothing marked.
        send_word(make_word(FUNC_ADD, 0, 32767));
        drain();

        // The kernel end raises the start above the low limit.
        set_config(15'd1000, 15'd30000);
        send_word(make_word(FUNC_ADD, 29000, 3768));
        // The last aligned group would run off the pool end and must not be taken.
        send_word(make_word(FUNC_ALLOC, 0, 2200));
        send_word(make_word(FUNC_ALLOC, 0, 2000));
        send_word(make_word(FUNC_FREE, 30000, 2000));

        // Random part in three phases with different idling on each side.
        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    set_config(LOW_LIMIT_RESET, KERNEL_END_RESET);
                    req_idle_pct = 38;
                    rsp_idle_pct = 75;
                end
                1:
                begin
                    set_config(PAGE_W'($urandom_range(512)), PAGE_W'($urandom_range(1024)));
                    req_idle_pct = 75;
                    rsp_idle_pct = 38;
                end
                default:
                begin
                    set_config(PAGE_W'($urandom_range(2048)), PAGE_W'($urandom_range(600)));
                    req_idle_pct = 0;
                    rsp_idle_pct = 0;
                    // Stall the receiver for a long stretch while the sender keeps
                    // offering, so the result register fills and input backs up.
                    hold_left = HOLD_CYCLES;
                end
            endcase
            repeat (WORDS_PER_PHASE) send_word(pick_word());
        end
        req_bus.valid <= 1'b0;

        while (book.pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (book.errors == 0 && book.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
